// ===== rtl/mini_risc16_instruction_step_unit_assert.svh =====
// Assertion macros used by the checker file of the instruction step unit.
`ifndef MINI_RISC16_INSTRUCTION_STEP_UNIT_ASSERT_SVH
`define MINI_RISC16_INSTRUCTION_STEP_UNIT_ASSERT_SVH

// Same-cycle implication, switched off while reset is held.
`define MRS16_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mrs16 check failed");

// Next-cycle implication, switched off while reset is held.
`define MRS16_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mrs16 check failed");

// Next-cycle implication that also holds across reset.
`define MRS16_ASSERT_RST(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("mrs16 reset check failed");

`endif

// ===== rtl/mrs16_pkg.sv =====
// Types, constants and codes of the 16-bit instruction step unit.
package mrs16_pkg;

  localparam int XLEN       = 32;
  localparam int PC_W       = 12;
  localparam int LEN_W      = 13;
  localparam int NUM_REGS   = 8;
  localparam int REG_AW     = $clog2(NUM_REGS);
  localparam int IMM_W      = 6;
  // Data memory depth; a power of two, so the address wraps by masking.
  localparam int DATA_DEPTH = 256;
  localparam int DADDR_W    = $clog2(DATA_DEPTH);
  localparam int MADDR_W    = 8;
  localparam int CFG_AW     = 3;

  localparam logic [3:0] OP_RTYPE = 4'd0;
  localparam logic [3:0] OP_JUMP  = 4'd2;
  localparam logic [3:0] OP_LW    = 4'd4;
  localparam logic [3:0] OP_SW    = 4'd5;
  localparam logic [3:0] OP_ADDI  = 4'd8;
  localparam logic [3:0] OP_BEQ   = 4'd9;

  localparam logic [2:0] FN_ADD = 3'd0;
  localparam logic [2:0] FN_SUB = 3'd1;
  localparam logic [2:0] FN_AND = 3'd2;
  localparam logic [2:0] FN_OR  = 3'd3;

  localparam logic ACT_EXEC = 1'b0;
  localparam logic ACT_BACK = 1'b1;

  // Register index as seen in bit 2 of the byte address.
  localparam logic CFG_IDX_PROG_LEN = 1'b0;

  typedef struct packed {
    logic        action;
    logic [15:0] instruction_word;
  } in_word_t;

  typedef struct packed {
    logic                   executed;
    logic [PC_W-1:0]        next_pc;
    logic                   reg_written;
    logic [REG_AW-1:0]      reg_index;
    logic signed [XLEN-1:0] reg_value;
    logic                   mem_written;
    logic [MADDR_W-1:0]     mem_address;
    logic signed [XLEN-1:0] mem_value;
    logic                   program_done;
  } out_word_t;

  typedef struct packed {
    out_word_t          res;
    logic               save_prev;
    logic               is_load;
    logic [DADDR_W-1:0] mem_idx;
  } exec_t;

  typedef struct packed {
    logic              re;
    logic [REG_AW-1:0] rs;
    logic [REG_AW-1:0] rt;
  } rf_rd_t;

  typedef struct packed {
    logic              we;
    logic [REG_AW-1:0] idx;
    logic [XLEN-1:0]   data;
  } rf_wr_t;

endpackage

// ===== rtl/mrs16_regfile.sv =====
// Register file with registered operand outputs that follow later writes.
module mrs16_regfile (
  input  logic                            clk,
  input  logic                            rst_n,
  input  mrs16_pkg::rf_rd_t               rd,
  input  mrs16_pkg::rf_wr_t               wr,
  output logic [mrs16_pkg::XLEN-1:0]      op_a,
  output logic [mrs16_pkg::XLEN-1:0]      op_b
);
  import mrs16_pkg::*;

  logic [XLEN-1:0]   regs_r [NUM_REGS];
  logic [XLEN-1:0]   a_r, a_nxt, b_r, b_nxt;
  logic [REG_AW-1:0] a_idx_r, b_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs_r[i] <= '0;
      end
    end else if (wr.we) begin
      regs_r[wr.idx] <= wr.data;
    end
  end

  // A fresh read sees a write of the same edge; a held operand picks up any
  // write to its register that lands while the word waits to execute.
  always_comb begin
    a_nxt = a_r;
    b_nxt = b_r;
    if (rd.re) begin
      a_nxt = (wr.we && wr.idx == rd.rs) ? wr.data : regs_r[rd.rs];
      b_nxt = (wr.we && wr.idx == rd.rt) ? wr.data : regs_r[rd.rt];
    end else begin
      if (wr.we && wr.idx == a_idx_r) a_nxt = wr.data;
      if (wr.we && wr.idx == b_idx_r) b_nxt = wr.data;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    if (rd.re) begin
      a_idx_r <= rd.rs;
      b_idx_r <= rd.rt;
    end
  end

  assign op_a = a_r;
  assign op_b = b_r;

endmodule

// ===== rtl/mrs16_dmem.sv =====
// Data memory with a clearing pass after reset and a registered read port.
module mrs16_dmem (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            re,
  input  logic                            we,
  input  logic [mrs16_pkg::DADDR_W-1:0]   addr,
  input  logic [mrs16_pkg::XLEN-1:0]      wdata,
  output logic [mrs16_pkg::XLEN-1:0]      rdata,
  output logic                            busy
);
  import mrs16_pkg::*;

  logic [XLEN-1:0]    mem [DATA_DEPTH];
  logic [XLEN-1:0]    rdata_r;
  logic               clr_r;
  logic [DADDR_W-1:0] clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
    end else if (clr_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == DADDR_W'(DATA_DEPTH - 1)) clr_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_r) begin
      mem[clr_cnt_r] <= '0;
    end else if (we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;
  assign busy  = clr_r;

endmodule

// ===== rtl/mrs16_exec.sv =====
// Decode and execute of one instruction word against the current state.
module mrs16_exec (
  input  mrs16_pkg::in_word_t             word,
  input  logic [mrs16_pkg::PC_W-1:0]      pc,
  input  logic [mrs16_pkg::PC_W-1:0]      prev_pc,
  input  logic                            prev_valid,
  input  logic [mrs16_pkg::LEN_W-1:0]     prog_len,
  input  logic [mrs16_pkg::XLEN-1:0]      op_a,
  input  logic [mrs16_pkg::XLEN-1:0]      op_b,
  output mrs16_pkg::exec_t                ex
);
  import mrs16_pkg::*;

  logic [3:0]        op;
  logic [REG_AW-1:0] rt, rd;
  logic [2:0]        funct;
  logic [IMM_W-1:0]  imm;
  logic [XLEN-1:0]   imm_x, sum, alu;
  logic [PC_W-1:0]   pc_inc;
  logic [XLEN-1:0]   idx_x;

  assign op     = word.instruction_word[15:12];
  assign rt     = word.instruction_word[8:6];
  assign rd     = word.instruction_word[5:3];
  assign funct  = word.instruction_word[2:0];
  assign imm    = word.instruction_word[IMM_W-1:0];
  assign imm_x  = XLEN'(imm);
  assign sum    = op_a + imm_x;
  assign pc_inc = pc + 1'b1;
  assign idx_x  = XLEN'(sum[DADDR_W-1:0]);

  always_comb begin
    case (funct)
      FN_ADD:  alu = op_a + op_b;
      FN_SUB:  alu = op_a - op_b;
      FN_AND:  alu = op_a & op_b;
      FN_OR:   alu = op_a | op_b;
      default: alu = '0;
    endcase
  end

  always_comb begin
    ex             = '0;
    ex.res.next_pc = pc;
    if (word.action == ACT_BACK) begin
      if (prev_valid) begin
        ex.res.executed = 1'b1;
        ex.res.next_pc  = prev_pc;
      end
    end else if ({1'b0, pc} < prog_len) begin
      ex.res.executed = 1'b1;
      ex.save_prev    = 1'b1;
      ex.res.next_pc  = pc_inc;
      case (op)
        OP_RTYPE: begin
          ex.res.reg_written = 1'b1;
          ex.res.reg_index   = rd;
          ex.res.reg_value   = $signed(alu);
        end
        OP_JUMP: begin
          ex.res.next_pc = word.instruction_word[PC_W-1:0];
        end
        OP_ADDI: begin
          ex.res.reg_written = 1'b1;
          ex.res.reg_index   = rt;
          ex.res.reg_value   = $signed(sum);
        end
        OP_BEQ: begin
          if (op_a == op_b) ex.res.next_pc = pc_inc + PC_W'(imm);
        end
        OP_LW: begin
          // The value comes from the registered memory read port in the following cycle.
          ex.is_load         = 1'b1;
          ex.mem_idx         = sum[DADDR_W-1:0];
          ex.res.mem_address = idx_x[MADDR_W-1:0];
          ex.res.reg_written = 1'b1;
          ex.res.reg_index   = rt;
        end
        OP_SW: begin
          ex.mem_idx         = sum[DADDR_W-1:0];
          ex.res.mem_address = idx_x[MADDR_W-1:0];
          ex.res.mem_written = 1'b1;
          ex.res.mem_value   = $signed(op_b);
        end
        default: begin
        end
      endcase
    end
    ex.res.program_done = ({1'b0, ex.res.next_pc} >= prog_len);
  end

endmodule

// ===== rtl/mini_risc16_instruction_step_unit.sv =====
// Top level of the 16-bit instruction step unit.
//
//   Port group   Direction   Moves
//   in_*         input       one instruction word or back action per word
//   out_*        output      one step result per input word
//   APB          both        program_length register at byte address 0
//
// A word moves from the input register through the execute logic into the
// result register; a load's data comes from the synchronous read port of the
// data memory before the register is written.
// After reset the data memory is cleared through all DATA_DEPTH (256) entries,
// and no word is accepted until then; register writes are taken throughout.
// A held result stalls execution, while an empty input register still takes a word.
module mini_risc16_instruction_step_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  mrs16_pkg::in_word_t                  in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output mrs16_pkg::out_word_t                 out_data,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [mrs16_pkg::CFG_AW-1:0]         paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);
  import mrs16_pkg::*;

  logic [LEN_W-1:0] prog_len_r;
  logic [PC_W-1:0]  pc_r, prev_pc_r;
  logic             prev_valid_r;
  logic             s1_valid_r;
  in_word_t         s1_word_r;
  logic             load_pend_r;
  logic             out_valid_r;
  out_word_t        out_data_r;

  logic             accept, exec_fire, dm_busy, cfg_wr;
  logic [XLEN-1:0]  op_a, op_b, dm_rdata;
  exec_t            ex;
  rf_rd_t           rf_rd;
  rf_wr_t           rf_wr;

  assign cfg_wr = psel && penable && pwrite && (paddr[2] == CFG_IDX_PROG_LEN);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == CFG_IDX_PROG_LEN) ? 32'(prog_len_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prog_len_r <= '0;
    end else if (cfg_wr) begin
      prog_len_r <= pwdata[LEN_W-1:0];
    end
  end

  // The slot ahead is free whenever execution fires, and a pending load
  // always finds it empty.
  assign exec_fire = s1_valid_r && !load_pend_r && (!out_valid_r || out_ready);
  assign in_ready  = !dm_busy && (!s1_valid_r || exec_fire);
  assign accept    = in_valid && in_ready;

  assign rf_rd.re = accept;
  assign rf_rd.rs = in_data.instruction_word[11:9];
  assign rf_rd.rt = in_data.instruction_word[8:6];

  always_comb begin
    if (load_pend_r) begin
      rf_wr.we   = 1'b1;
      rf_wr.idx  = out_data_r.reg_index;
      rf_wr.data = dm_rdata;
    end else begin
      rf_wr.we   = exec_fire && ex.res.reg_written && !ex.is_load;
      rf_wr.idx  = ex.res.reg_index;
      rf_wr.data = ex.res.reg_value;
    end
  end

  mrs16_regfile u_regfile (
    .clk   (clk),
    .rst_n (rst_n),
    .rd    (rf_rd),
    .wr    (rf_wr),
    .op_a  (op_a),
    .op_b  (op_b)
  );

  mrs16_exec u_exec (
    .word       (s1_word_r),
    .pc         (pc_r),
    .prev_pc    (prev_pc_r),
    .prev_valid (prev_valid_r),
    .prog_len   (prog_len_r),
    .op_a       (op_a),
    .op_b       (op_b),
    .ex         (ex)
  );

  mrs16_dmem u_dmem (
    .clk   (clk),
    .rst_n (rst_n),
    .re    (exec_fire && ex.is_load),
    .we    (exec_fire && ex.res.mem_written),
    .addr  (ex.mem_idx),
    .wdata (ex.res.mem_value),
    .rdata (dm_rdata),
    .busy  (dm_busy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      load_pend_r  <= 1'b0;
      out_valid_r  <= 1'b0;
      pc_r         <= '0;
      prev_pc_r    <= '0;
      prev_valid_r <= 1'b0;
    end else begin
      if (accept)         s1_valid_r <= 1'b1;
      else if (exec_fire) s1_valid_r <= 1'b0;

      if (exec_fire) begin
        pc_r <= ex.res.next_pc;
        if (ex.save_prev) begin
          prev_pc_r    <= pc_r;
          prev_valid_r <= 1'b1;
        end
      end

      if (load_pend_r) begin
        load_pend_r <= 1'b0;
        out_valid_r <= 1'b1;
      end else if (exec_fire) begin
        load_pend_r <= ex.is_load;
        out_valid_r <= !ex.is_load;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) s1_word_r <= in_data;
    if (load_pend_r) begin
      out_data_r.reg_value <= $signed(dm_rdata);
    end else if (exec_fire) begin
      out_data_r <= ex.res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/mrs16_checker.sv =====
// Port-level checks of the instruction step unit, bound to the top level.
`include "mini_risc16_instruction_step_unit_assert.svh"

module mrs16_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input mrs16_pkg::out_word_t  out_data
);
  import mrs16_pkg::*;

  // Reset empties the result slot and starts the memory clearing pass.
  `MRS16_ASSERT_RST(a_rst_empty, clk, !rst_n, !out_valid && !in_ready)

  // A result that is not taken holds.
  `MRS16_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

  // Register fields are zero when no register is written.
  `MRS16_ASSERT_IMP(a_reg_quiet, clk, rst_n, out_valid && !out_data.reg_written, out_data.reg_index == '0 && out_data.reg_value == '0)

  // A step that had no effect writes nothing and names no address.
  `MRS16_ASSERT_IMP(a_noexec_quiet, clk, rst_n, out_valid && !out_data.executed, !out_data.reg_written && !out_data.mem_written && out_data.mem_address == '0)

endmodule

bind mini_risc16_instruction_step_unit mrs16_checker u_mrs16_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== verif/tb_mini_risc16_instruction_step_unit.sv =====
// Self-checking testbench of the 16-bit instruction step unit.
`timescale 1ns / 100ps

module tb_mini_risc16_instruction_step_unit;
  import mrs16_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam logic [CFG_AW-1:0] PROG_LEN_ADDR = {CFG_IDX_PROG_LEN, 2'b00};

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  in_word_t          in_data;
  logic              out_valid;
  logic              out_ready;
  out_word_t         out_data;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  // Shadow copy of the architectural state, used to work out each step result.
  logic [XLEN-1:0]  shadow_regs [NUM_REGS];
  logic [XLEN-1:0]  shadow_dmem [DATA_DEPTH];
  logic [PC_W-1:0]  shadow_pc;
  logic [PC_W-1:0]  shadow_prev_pc;
  logic             shadow_prev_valid;
  logic [LEN_W-1:0] shadow_prog_len;

  out_word_t   pending_results [$];
  int unsigned err_count;
  int unsigned words_sent;
  int unsigned results_seen;
  int unsigned len_writes;
  int unsigned cycle_count;
  int unsigned burst_left;

  mini_risc16_instruction_step_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out after %0d cycles", cycle_count);
    $display("FAILURE");
    $finish;
  end

  function automatic logic [15:0] enc_r(logic [2:0] rs, logic [2:0] rt, logic [2:0] rd,
                                        logic [2:0] fn);
    return {OP_RTYPE, rs, rt, rd, fn};
  endfunction

  function automatic logic [15:0] enc_i(logic [3:0] op, logic [2:0] rs, logic [2:0] rt,
                                        logic [5:0] imm);
    return {op, rs, rt, imm};
  endfunction

  function automatic logic [15:0] enc_j(logic [11:0] target);
    return {OP_JUMP, target};
  endfunction

  function automatic out_word_t compute_step_result(in_word_t w);
    out_word_t        r;
    logic [3:0]       op;
    logic [2:0]       rs;
    logic [2:0]       rt;
    logic [2:0]       rd;
    logic [2:0]       fn;
    logic [5:0]       imm;
    logic [XLEN-1:0]  a;
    logic [XLEN-1:0]  b;
    logic [XLEN-1:0]  v;
    logic [XLEN-1:0]  addr_sum;
    logic [DADDR_W-1:0] idx;
    logic [PC_W-1:0]  nxt;
    r = '0;
    if (w.action == ACT_BACK) begin
      if (shadow_prev_valid) begin
        shadow_pc  = shadow_prev_pc;
        r.executed = 1'b1;
      end
    end else if ({1'b0, shadow_pc} < shadow_prog_len) begin
      op  = w.instruction_word[15:12];
      rs  = w.instruction_word[11:9];
      rt  = w.instruction_word[8:6];
      rd  = w.instruction_word[5:3];
      fn  = w.instruction_word[2:0];
      imm = w.instruction_word[5:0];
      a   = shadow_regs[rs];
      b   = shadow_regs[rt];
      nxt = shadow_pc + 1'b1;
      addr_sum = a + imm;
      // The depth is a power of two, so the low bits give the wrapped address.
      idx = addr_sum[DADDR_W-1:0];
      r.executed        = 1'b1;
      shadow_prev_pc    = shadow_pc;
      shadow_prev_valid = 1'b1;
      case (op)
        OP_RTYPE: begin
          case (fn)
            FN_ADD:  v = a + b;
            FN_SUB:  v = a - b;
            FN_AND:  v = a & b;
            FN_OR:   v = a | b;
            default: v = '0;
          endcase
          r.reg_written = 1'b1;
          r.reg_index   = rd;
          r.reg_value   = v;
        end
        OP_JUMP: nxt = w.instruction_word[PC_W-1:0];
        OP_ADDI: begin
          r.reg_written = 1'b1;
          r.reg_index   = rt;
          r.reg_value   = a + imm;
        end
        OP_BEQ: begin
          if (a == b) nxt = shadow_pc + imm + 1'b1;
        end
        OP_LW: begin
          r.mem_address = idx;
          r.reg_written = 1'b1;
          r.reg_index   = rt;
          r.reg_value   = shadow_dmem[idx];
        end
        OP_SW: begin
          r.mem_address    = idx;
          r.mem_written    = 1'b1;
          r.mem_value      = b;
          shadow_dmem[idx] = b;
        end
        default: ;
      endcase
      if (r.reg_written) shadow_regs[r.reg_index] = r.reg_value;
      shadow_pc = nxt;
    end
    r.next_pc      = shadow_pc;
    r.program_done = ({1'b0, shadow_pc} >= shadow_prog_len);
    return r;
  endfunction

  // Entered and left at a falling edge. Words go out in bursts; valid stays
  // high from one word to the next inside a burst.
  task automatic send_word(in_word_t w);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(compute_step_result(w));
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_exec(logic [15:0] iw);
    in_word_t w;
    w.action           = ACT_EXEC;
    w.instruction_word = iw;
    send_word(w);
  endtask

  task automatic send_back();
    in_word_t w;
    w.action           = ACT_BACK;
    w.instruction_word = 16'($urandom);
    send_word(w);
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    burst_left = 0;
  endtask

  // Waits for a further falling edge after the transfer, so that a following
  // transfer never drives the port twice at the same edge.
  task automatic apb_transfer(input logic wr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= PROG_LEN_ADDR;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // Only called while the block is idle.
  task automatic set_program_length(int unsigned len);
    logic [31:0] rd;
    apb_transfer(1'b1, len, rd);
    shadow_prog_len = len[LEN_W-1:0];
    len_writes++;
    apb_transfer(1'b0, '0, rd);
    if (rd !== 32'(shadow_prog_len)) begin
      $error("program_length readback: expected 0x%0h, got 0x%0h", shadow_prog_len, rd);
      err_count++;
    end
  endtask

  function automatic in_word_t random_instruction(int unsigned len);
    in_word_t   w;
    int unsigned pick;
    logic [11:0] target;
    pick = $urandom_range(0, 99);
    w.action           = ACT_EXEC;
    w.instruction_word = 16'($urandom);
    if (len > 0 && $urandom_range(0, 3) != 0)
      target = 12'($urandom_range(0, len - 1));
    else
      target = 12'($urandom);
    if (pick < 10)
      w.action = ACT_BACK;
    else if (pick < 30)
      w.instruction_word[15:12] = OP_RTYPE;
    else if (pick < 45)
      w.instruction_word[15:12] = OP_ADDI;
    else if (pick < 57)
      w.instruction_word[15:12] = OP_LW;
    else if (pick < 69)
      w.instruction_word[15:12] = OP_SW;
    else if (pick < 79)
      w.instruction_word[15:12] = OP_BEQ;
    else if (pick < 87)
      w.instruction_word = enc_j(target);
    else if (pick < 97)
      w.instruction_word[15:12] = 4'($urandom_range(0, 15));
    else
      w.action = 1'($urandom);
    return w;
  endfunction

  task automatic test_reset_state();
    // With no program loaded the step does nothing, and there is nothing to go back to.
    send_exec(enc_i(OP_ADDI, 3'd0, 3'd1, 6'd5));
    send_back();
    wait_results_drained();
    set_program_length(4096);
  endtask

  task automatic test_alu_ops();
    send_exec(enc_i(OP_ADDI, 3'd0, 3'd1, 6'd63));
    send_exec(enc_i(OP_ADDI, 3'd0, 3'd2, 6'd1));
    send_exec(enc_r(3'd1, 3'd2, 3'd3, FN_ADD));
    send_exec(enc_r(3'd2, 3'd1, 3'd4, FN_SUB));
    send_exec(enc_r(3'd1, 3'd2, 3'd5, FN_AND));
    send_exec(enc_r(3'd4, 3'd2, 3'd6, FN_OR));
    send_exec(enc_r(3'd1, 3'd2, 3'd7, 3'd7));
    send_exec(enc_r(3'd1, 3'd2, 3'd0, 3'd4));
    // Register zero is an ordinary register: -62 + 63 lands in it.
    send_exec(enc_i(OP_ADDI, 3'd4, 3'd0, 6'd63));
  endtask

  task automatic test_memory();
    send_exec(enc_i(OP_SW, 3'd1, 3'd4, 6'd63));
    send_exec(enc_i(OP_LW, 3'd1, 3'd5, 6'd63));
    // A negative base plus the immediate gives address 1 here.
    send_exec(enc_i(OP_SW, 3'd4, 3'd3, 6'd63));
    send_exec(enc_i(OP_LW, 3'd0, 3'd6, 6'd0));
    send_exec(enc_i(OP_LW, 3'd2, 3'd7, 6'd40));
  endtask

  task automatic test_control_flow();
    send_exec(enc_i(OP_BEQ, 3'd1, 3'd1, 6'd63));
    send_exec(enc_i(OP_BEQ, 3'd1, 3'd2, 6'd5));
    send_exec(enc_j(12'hFFF));
    // An unused opcode only advances the counter, which wraps to zero here.
    send_exec(16'hFFFF);
  endtask

  task automatic test_back_action();
    send_back();
    send_back();
    send_exec(enc_j(12'h000));
  endtask

  task automatic test_program_end();
    wait_results_drained();
    set_program_length(1);
    send_exec(enc_i(OP_ADDI, 3'd2, 3'd2, 6'd1));
    send_exec(enc_i(OP_ADDI, 3'd2, 3'd2, 6'd1));
    send_back();
  endtask

  task automatic test_random_phase(int unsigned len, int unsigned count);
    wait_results_drained();
    set_program_length(len);
    repeat (count) send_word(random_instruction(len));
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      err_count++;
    end
  endtask

  always @(posedge clk) begin : result_checker
    out_word_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("Result word with no expectation waiting");
        err_count++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("executed",     32'(exp_r.executed),     32'(out_data.executed));
        check_field("next_pc",      32'(exp_r.next_pc),      32'(out_data.next_pc));
        check_field("reg_written",  32'(exp_r.reg_written),  32'(out_data.reg_written));
        check_field("reg_index",    32'(exp_r.reg_index),    32'(out_data.reg_index));
        check_field("reg_value",    exp_r.reg_value,         out_data.reg_value);
        check_field("mem_written",  32'(exp_r.mem_written),  32'(out_data.mem_written));
        check_field("mem_address",  32'(exp_r.mem_address),  32'(out_data.mem_address));
        check_field("mem_value",    exp_r.mem_value,         out_data.mem_value);
        check_field("program_done", 32'(exp_r.program_done), 32'(out_data.program_done));
      end
    end
  end

  // The receiver switches between stall patterns of random length.
  initial begin : receiver_stalls
    int unsigned mode;
    int unsigned span;
    int unsigned period;
    int unsigned step;
    out_ready = 1'b0;
    forever begin
      mode   = $urandom_range(0, 3);
      span   = $urandom_range(16, 96);
      period = $urandom_range(2, 7);
      for (step = 0; step < span; step++) begin
        @(negedge clk);
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom);
          2:       out_ready <= (step % period) != 0;
          default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    err_count    = 0;
    words_sent   = 0;
    results_seen = 0;
    len_writes   = 0;
    burst_left   = 0;
    shadow_pc         = '0;
    shadow_prev_pc    = '0;
    shadow_prev_valid = 1'b0;
    shadow_prog_len   = '0;
    foreach (shadow_regs[i]) shadow_regs[i] = '0;
    foreach (shadow_dmem[i]) shadow_dmem[i] = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_alu_ops();
    test_memory();
    test_control_flow();
    test_back_action();
    test_program_end();
    test_random_phase(4096, 300);
    test_random_phase($urandom_range(100, 4095), 150);
    test_random_phase(16, 100);
    test_random_phase(1, 60);
    test_random_phase(0, 20);
    test_random_phase(4096, 100);
    wait_results_drained();
    repeat (20) @(posedge clk);

    $display("Stepped %0d words and checked %0d results over %0d program_length settings,",
             words_sent, results_seen, len_writes);
    $display("covering every operation, back actions, wraps and steps past the end.");
    if (err_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
